// ===== rtl/dnc_pkg.sv =====
package dnc_pkg;

   // Sizes fixed by the field definitions
   localparam int SYM_W      = 4;
   localparam int DIG_W      = 4;
   localparam int SIG_W      = 6;
   localparam int EXP_W      = 9;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Default depth of the digit stores
   localparam int MAX_DIGITS_DEF = 32;

   // Exponent saturation bound
   localparam int EXP_LIMIT = 255;

   // Symbol codes
   localparam logic [SYM_W-1:0] SYM_ZERO      = 4'd0;
   localparam logic [SYM_W-1:0] SYM_DIGIT_MAX = 4'd9;
   localparam logic [SYM_W-1:0] SYM_POINT     = 4'd10;

   // Reset value of the significant digit count
   localparam logic [SIG_W-1:0] SIG_RESET = 6'd3;

   // Parser phase
   typedef enum logic [1:0] {
      PH_LEAD,
      PH_FRAC_ZERO,
      PH_INT,
      PH_FRAC
   } parse_phase_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_PARSE,
      ST_READ,
      ST_LOAD,
      ST_SEND
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;   // symbol word taken this cycle
      logic load;     // capture next result into output register
      logic advance;  // step to next mantissa digit
      logic finish;   // run done: store first number, clear parser
   } dnc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_digit;  // digit index is on the final mantissa digit
   } dnc_status_type;

endpackage

// ===== rtl/dnc_ctrl.sv =====
module dnc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  dnc_pkg::dnc_status_type status,
   output dnc_pkg::dnc_cmd_type    cmd
);

   dnc_pkg::ctrl_state_type state_ff;
   dnc_pkg::ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dnc_pkg::ST_PARSE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dnc_pkg::ST_PARSE: begin
            if (req_tvalid && req_tlast) state_in = dnc_pkg::ST_READ;
         end
         dnc_pkg::ST_READ: begin
            state_in = dnc_pkg::ST_LOAD;
         end
         dnc_pkg::ST_LOAD: begin
            state_in = dnc_pkg::ST_SEND;
         end
         dnc_pkg::ST_SEND: begin
            if (rsp_tready) begin
               state_in = status.last_digit ? dnc_pkg::ST_PARSE : dnc_pkg::ST_READ;
            end
         end
         default: begin
            state_in = dnc_pkg::ST_PARSE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         dnc_pkg::ST_PARSE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         dnc_pkg::ST_READ: begin
         end
         dnc_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
         end
         dnc_pkg::ST_SEND: begin
            rsp_tvalid  = 1'b1;
            cmd.advance = rsp_tready && !status.last_digit;
            cmd.finish  = rsp_tready && status.last_digit;
         end
         default: begin
         end
      endcase
   end

   // no input taken while a result word is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted during result emission");

   // final digit taken returns to parsing
   a_back_to_parse: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && status.last_digit) |=> req_tready)
      else $error("controller did not return to parsing after final digit");

endmodule

// ===== rtl/dnc_datapath.sv =====
module dnc_datapath #(
   parameter int MAX_DIGITS = dnc_pkg::MAX_DIGITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dnc_pkg::SIG_W-1:0]       csr_wdata,
   input  logic [dnc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  dnc_pkg::dnc_cmd_type            cmd,
   output dnc_pkg::dnc_status_type         status,
   output logic [dnc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int EXP_W = dnc_pkg::EXP_W;
   localparam int DIG_W = dnc_pkg::DIG_W;
   localparam int SIG_W = dnc_pkg::SIG_W;
   localparam logic signed [EXP_W-1:0] EXP_HI  = EXP_W'(dnc_pkg::EXP_LIMIT);
   localparam logic signed [EXP_W-1:0] EXP_LO  = -EXP_HI;
   localparam logic signed [EXP_W-1:0] EXP_ONE = EXP_W'(1);
   localparam logic [SIG_W:0]          MAX_EXT = (SIG_W + 1)'(MAX_DIGITS);

   // configuration
   logic [SIG_W-1:0] sig_ff;

   // parser state
   dnc_pkg::parse_phase_type phase_ff, phase_in;
   logic signed [EXP_W-1:0]  exp_ff, exp_in;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     which_ff;

   // stored first number
   logic signed [EXP_W-1:0]  first_exp_ff;
   logic [CNT_W-1:0]         first_cnt_ff;

   // emission
   logic [IDX_W-1:0]         idx_ff;
   logic                     same_ff;
   logic [DIG_W-1:0]         rd_cur_ff;
   logic [DIG_W-1:0]         rd_first_ff;

   // output register
   logic [DIG_W-1:0]         digit_ff;
   logic signed [EXP_W-1:0]  exp_out_ff;
   logic                     id_ff;
   logic                     last_ff;
   logic                     equal_ff;

   // digit stores
   logic [DIG_W-1:0] cur_mem   [MAX_DIGITS];
   logic [DIG_W-1:0] first_mem [MAX_DIGITS];

   logic [dnc_pkg::SYM_W-1:0] sym;
   logic                      is_digit;
   logic                      is_point;
   logic                      sym_nonzero;
   logic                      take;
   logic                      keep;
   logic [CNT_W-1:0]          n_eff;
   logic [CNT_W-1:0]          idx_ext;
   logic [DIG_W-1:0]          d_cur;
   logic [DIG_W-1:0]          d_first;
   logic signed [EXP_W-1:0]   e_val;
   logic                      same_in;

   assign sym         = req_tdata[dnc_pkg::SYM_W-1:0];
   assign is_digit    = (sym <= dnc_pkg::SYM_DIGIT_MAX);
   assign is_point    = (sym == dnc_pkg::SYM_POINT);
   assign sym_nonzero = (sym != dnc_pkg::SYM_ZERO);
   assign idx_ext     = CNT_W'(idx_ff);

   // effective digit count: clamp register to 1..MAX_DIGITS
   always_comb begin
      priority if (sig_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if ({1'b0, sig_ff} > MAX_EXT) begin
         n_eff = CNT_W'(MAX_DIGITS);
      end else begin
         n_eff = CNT_W'(sig_ff);
      end
   end

   // symbol parser: next phase and exponent
   always_comb begin
      phase_in = phase_ff;
      exp_in   = exp_ff;
      take     = 1'b0;
      if (is_digit) begin
         unique case (phase_ff)
            dnc_pkg::PH_LEAD: begin
               if (sym_nonzero) begin
                  take     = 1'b1;
                  exp_in   = EXP_ONE;
                  phase_in = dnc_pkg::PH_INT;
               end
            end
            dnc_pkg::PH_FRAC_ZERO: begin
               if (sym_nonzero) begin
                  take     = 1'b1;
                  phase_in = dnc_pkg::PH_FRAC;
               end else if (exp_ff > EXP_LO) begin
                  exp_in = exp_ff - EXP_ONE;
               end
            end
            dnc_pkg::PH_INT: begin
               take = 1'b1;
               if (exp_ff < EXP_HI) exp_in = exp_ff + EXP_ONE;
            end
            dnc_pkg::PH_FRAC: begin
               take = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (is_point) begin
         if (phase_ff == dnc_pkg::PH_LEAD) phase_in = dnc_pkg::PH_FRAC_ZERO;
         else if (phase_ff == dnc_pkg::PH_INT) phase_in = dnc_pkg::PH_FRAC;
      end
   end

   assign keep = take && (cnt_ff < n_eff);

   // result digit, stored first digit (padded) and exponent of this number
   always_comb begin
      d_cur   = (idx_ext < cnt_ff) ? rd_cur_ff : '0;
      d_first = (idx_ext < first_cnt_ff) ? rd_first_ff : '0;
      e_val   = (phase_ff == dnc_pkg::PH_INT || phase_ff == dnc_pkg::PH_FRAC) ? exp_ff : '0;
      same_in = ((idx_ff == '0) ? (e_val == first_exp_ff) : same_ff) && (d_cur == d_first);
   end

   assign status.last_digit = (idx_ext == n_eff - CNT_W'(1));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff       <= dnc_pkg::SIG_RESET;
         phase_ff     <= dnc_pkg::PH_LEAD;
         exp_ff       <= '0;
         cnt_ff       <= '0;
         first_exp_ff <= '0;
         first_cnt_ff <= '0;
         idx_ff       <= '0;
         same_ff      <= 1'b0;
      end else begin
         if (csr_we) sig_ff <= csr_wdata;
         if (cmd.accept) begin
            phase_ff <= phase_in;
            exp_ff   <= exp_in;
            if (keep) cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.load) same_ff <= same_in;
         if (cmd.advance) idx_ff <= idx_ff + IDX_W'(1);
         if (cmd.finish) begin
            if (!which_ff) begin
               first_exp_ff <= e_val;
               first_cnt_ff <= n_eff;
            end
            phase_ff <= dnc_pkg::PH_LEAD;
            exp_ff   <= '0;
            cnt_ff   <= '0;
            idx_ff   <= '0;
         end
      end
   end

   // number id: value on the final symbol wins
   always_ff @(posedge clock) begin
      if (cmd.accept) which_ff <= req_tuser;
   end

   // digit stores, registered read
   always_ff @(posedge clock) begin
      if (cmd.accept && keep) cur_mem[cnt_ff[IDX_W-1:0]] <= sym;
      if (cmd.load && !which_ff) first_mem[idx_ff] <= d_cur;
      rd_cur_ff   <= cur_mem[idx_ff];
      rd_first_ff <= first_mem[idx_ff];
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         digit_ff   <= d_cur;
         exp_out_ff <= e_val;
         id_ff      <= which_ff;
         last_ff    <= status.last_digit;
         equal_ff   <= status.last_digit && which_ff && same_in;
      end
   end

   // tdata: digit, exponent, equal, zero fill
   assign rsp_tdata = {2'b00, equal_ff, exp_out_ff, digit_ff};
   assign rsp_tuser = id_ff;
   assign rsp_tlast = last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count beyond store depth");

   a_exp_bound: assert property (@(posedge clock) disable iff (reset)
      (exp_ff <= EXP_HI) && (exp_ff >= EXP_LO))
      else $error("running exponent out of saturation range");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (digit_ff <= DIG_W'(dnc_pkg::SYM_DIGIT_MAX)))
      else $error("emitted mantissa digit above nine");

endmodule

// ===== rtl/decimal_normalize_compare_unit.sv =====
// Takes two decimal numbers as a stream of symbol words (digit 0-9, or 10 for
// the point; req_tlast marks the last symbol, req_tuser says first or second
// number) and returns each one as csr-selected count n of mantissa digits,
// most significant first, with the saturated exponent of the 0.mantissa form.
// The final digit of the second number carries a flag that is set when both
// normalized forms match. Symbol words are taken back to back while the block
// parses. After the last symbol the block stops taking input and emits the n
// digits; each digit goes through a registered read of the digit store, an
// output register load and the result handshake, which waits while rsp_tready
// is low. No clearing pass is needed after reset. csr_wdata sets n; 0 acts as 1
// and values above MAX_DIGITS act as MAX_DIGITS. Write it only while no number
// is in progress.
module decimal_normalize_compare_unit #(
   parameter int MAX_DIGITS = dnc_pkg::MAX_DIGITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [dnc_pkg::SIG_W-1:0]       csr_wdata,   // sig_digits
   // symbol stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dnc_pkg::REQ_DATA_W-1:0]  req_tdata,   // [3:0] symbol, [7:4] zero
   input  logic                            req_tlast,   // last_symbol
   input  logic                            req_tuser,   // [0] which_number
   // mantissa digit stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dnc_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [3:0] digit, [12:4] exponent,
                                                        // [13] equal, [15:14] zero
   output logic                            rsp_tlast,   // last_digit
   output logic                            rsp_tuser    // [0] number_id
);

   dnc_pkg::dnc_cmd_type    cmd;
   dnc_pkg::dnc_status_type status;

   dnc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dnc_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// ===== dv/dnc_result_checker.sv =====
`timescale 1ns / 100ps

// Watches both streams and the csr port, predicts every mantissa digit word
// from the accepted symbol words, and compares each accepted result word
// against the oldest prediction.
module dnc_result_checker
   import dnc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [SIG_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tuser,
   output int                    errors,
   output int                    pending
);

   localparam int NDIG = MAX_DIGITS_DEF;

   typedef struct packed {
      logic [DIG_W-1:0]        digit;
      logic signed [EXP_W-1:0] exponent;
      logic                    number_id;
      logic                    last_digit;
      logic                    equal;
   } mantissa_digit_t;

   // predicted digit words not yet seen on the result stream
   mantissa_digit_t mantissa_q[$];

   // shadow of the block's configuration and parser state
   logic [SIG_W-1:0]        sig_digits;
   parse_phase_type         phase;
   logic signed [EXP_W-1:0] run_exp;
   logic signed [EXP_W-1:0] first_exp;
   logic [SIG_W:0]          kept;
   logic [DIG_W-1:0]        cur_dig[NDIG];
   logic [DIG_W-1:0]        first_dig[NDIG];
   int                      mismatches;

   // 0 acts as 1, above the store depth acts as the depth
   function automatic int unsigned digits_in_use();
      if (sig_digits == '0) return 1;
      if (sig_digits > NDIG) return NDIG;
      return sig_digits;
   endfunction

   task automatic keep_digit(input logic [DIG_W-1:0] d);
      if (kept < digits_in_use()) begin
         cur_dig[kept] = d;
         kept = kept + 1'b1;
      end
   endtask

   task automatic exp_step(input bit up);
      if (up && run_exp < EXP_LIMIT) run_exp = run_exp + 1'b1;
      if (!up && run_exp > -EXP_LIMIT) run_exp = run_exp - 1'b1;
   endtask

   // one symbol word; on the last symbol queue up the whole mantissa run
   task automatic normalize_symbol(input logic [SYM_W-1:0] sym, input logic last,
                                   input logic which);
      int unsigned             n;
      logic signed [EXP_W-1:0] e;
      logic [DIG_W-1:0]        d;
      bit                      same;
      mantissa_digit_t         w;
      if (sym <= SYM_DIGIT_MAX) begin
         case (phase)
            PH_LEAD: begin
               if (sym != SYM_ZERO) begin
                  keep_digit(sym);
                  run_exp = 1;
                  phase = PH_INT;
               end
            end
            PH_FRAC_ZERO: begin
               if (sym == SYM_ZERO) exp_step(1'b0);
               else begin
                  keep_digit(sym);
                  phase = PH_FRAC;
               end
            end
            PH_INT: begin
               keep_digit(sym);
               exp_step(1'b1);
            end
            default: keep_digit(sym);
         endcase
      end else if (sym == SYM_POINT) begin
         // a second point is dropped
         if (phase == PH_LEAD) phase = PH_FRAC_ZERO;
         else if (phase == PH_INT) phase = PH_FRAC;
      end
      if (last) begin
         n = digits_in_use();
         // no nonzero digit seen: exponent 0
         e = (phase == PH_INT || phase == PH_FRAC) ? run_exp : '0;
         same = (e == first_exp);
         for (int i = 0; i < n; i++) begin
            d = (i < kept) ? cur_dig[i] : SYM_ZERO;
            if (d != first_dig[i]) same = 0;
         end
         for (int i = 0; i < n; i++) begin
            w.digit      = (i < kept) ? cur_dig[i] : SYM_ZERO;
            w.exponent   = e;
            w.number_id  = which;
            w.last_digit = (i + 1 == n);
            w.equal      = (i + 1 == n) && which && same;
            mantissa_q.push_back(w);
         end
         // first number is stored padded out to the full depth
         if (!which) begin
            for (int i = 0; i < NDIG; i++)
               first_dig[i] = (i < kept && i < n) ? cur_dig[i] : SYM_ZERO;
            first_exp = e;
         end
         phase = PH_LEAD;
         run_exp = '0;
         kept = '0;
      end
   endtask

   task automatic check_digit(input mantissa_digit_t got);
      mantissa_digit_t want;
      if (mantissa_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected digit word: digit %0d exp %0d id %0d last %0d eq %0d",
                     $realtime, got.digit, got.exponent, got.number_id, got.last_digit,
                     got.equal);
      end else begin
         want = mantissa_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: digit word mismatch: expected digit %0d exp %0d id %0d last %0d eq %0d, got digit %0d exp %0d id %0d last %0d eq %0d",
                        $realtime, want.digit, want.exponent, want.number_id,
                        want.last_digit, want.equal, got.digit, got.exponent,
                        got.number_id, got.last_digit, got.equal);
         end
      end
   endtask

   initial begin
      mismatches = 0;
      errors     = 0;
      pending    = 0;
      for (int i = 0; i < NDIG; i++) begin
         cur_dig[i]   = '0;
         first_dig[i] = '0;
      end
   end

   // monitor: everything sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         sig_digits = SIG_RESET;
         phase      = PH_LEAD;
         run_exp    = '0;
         kept       = '0;
         first_exp  = '0;
         mantissa_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_digit(mantissa_digit_t'{rsp_tdata[3:0], rsp_tdata[12:4], rsp_tuser,
                                          rsp_tlast, rsp_tdata[13]});
         if (csr_we) sig_digits = csr_wdata;
         if (req_tvalid && req_tready)
            normalize_symbol(req_tdata[SYM_W-1:0], req_tlast, req_tuser);
      end
      errors  <= mismatches;
      pending <= mantissa_q.size();
   end

endmodule

// ===== dv/tb_decimal_normalize_compare_unit.sv =====
`timescale 1ns / 100ps

module tb_decimal_normalize_compare_unit;
   import dnc_pkg::*;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [SIG_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   int                    errors;
   int                    pending;

   // stimulus control
   bit                    no_idle      = 1'b0;
   bit                    rsp_hold_req = 1'b0;
   bit                    have_first   = 1'b0;
   int                    hold_left    = 0;
   int                    items_sent   = 0;
   logic [SYM_W-1:0]      sym_q[$];
   logic [SYM_W-1:0]      first_text_q[$];

   decimal_normalize_compare_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   dnc_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .errors     (errors),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bit idle_now();
      return !no_idle && ($urandom_range(0, 99) < 26);
   endfunction

   // receiver: random backpressure, plus a long counted hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_now();
         end
      end
   end

   // offer one symbol word and wait for it to be taken
   task automatic push_symbol(input logic [SYM_W-1:0] sym, input logic last,
                              input logic which);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-SYM_W){1'b0}}, sym};
      req_tlast  <= last;
      req_tuser  <= which;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (idle_now()) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (idle_now());
      end
   endtask

   // send sym_q as one number; only the final word's tuser counts
   task automatic send_number(input logic which);
      items_sent += sym_q.size();
      for (int i = 0; i < sym_q.size(); i++) begin
         if (i == sym_q.size() - 1) push_symbol(sym_q[i], 1'b1, which);
         else push_symbol(sym_q[i], 1'b0, 1'($urandom_range(0, 1)));
      end
      if (!which) begin
         first_text_q = sym_q;
         have_first = 1'b1;
      end
   endtask

   // digits, '.' for the point, 'a'..'e' for the unused codes
   task automatic send_text(input string s, input logic which);
      sym_q.delete();
      for (int i = 0; i < s.len(); i++) begin
         if (s[i] == ".") sym_q.push_back(SYM_POINT);
         else if (s[i] >= "0" && s[i] <= "9") sym_q.push_back(SYM_W'(s[i] - "0"));
         else sym_q.push_back(SYM_W'(SYM_POINT + 1 + (s[i] - "a")));
      end
      send_number(which);
   endtask

   task automatic build_random(input logic which);
      int r;
      int len;
      r = $urandom_range(0, 99);
      sym_q.delete();
      if (which && r < 30 && first_text_q.size() < 40) begin
         // same value with an extra leading zero: should compare equal
         sym_q = {SYM_ZERO, first_text_q};
      end else if (r < 45) begin
         // noise: any code, extra points, unused codes
         len = $urandom_range(1, 8);
         repeat (len) sym_q.push_back(SYM_W'($urandom_range(0, 15)));
      end else begin
         repeat ($urandom_range(0, 3)) sym_q.push_back(SYM_ZERO);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
         if (len > 0) sym_q.push_back(SYM_W'($urandom_range(1, 9)));
         repeat (len - 1) sym_q.push_back(SYM_W'($urandom_range(0, 9)));
         if ($urandom_range(0, 9) < 7) begin
            sym_q.push_back(SYM_POINT);
            repeat ($urandom_range(0, 3)) sym_q.push_back(SYM_ZERO);
            repeat ($urandom_range(0, 6)) sym_q.push_back(SYM_W'($urandom_range(0, 9)));
         end
         if (sym_q.size() == 0) sym_q.push_back(SYM_ZERO);
      end
   endtask

   // exponent overflow in either direction, just past the limit
   task automatic build_long(input bit negative);
      sym_q.delete();
      if (negative) begin
         sym_q.push_back(SYM_POINT);
         repeat (256) sym_q.push_back(SYM_ZERO);
         sym_q.push_back(SYM_W'(5));
      end else begin
         sym_q.push_back(SYM_W'(1));
         repeat (256) sym_q.push_back(SYM_W'($urandom_range(0, 9)));
      end
   endtask

   // stop offering and wait for every predicted digit word, then settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_sig_digits(input logic [SIG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // main stimulus
   initial begin
      logic [SIG_W-1:0] cfg_vals[8];
      logic             which;
      int               phase_no;
      cfg_vals = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd33, 6'd2, 6'd5, 6'd16};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed numbers at the reset digit count
      send_text("1.5", 1'b0);
      send_text("01.50", 1'b1);   // same value as the first
      send_text(".05", 1'b0);     // zeros after the point
      send_text("9a.9.", 1'b1);   // unused code and a second point
      send_text("000", 1'b1);     // no nonzero digit
      send_text(".", 1'b0);
      send_text("e", 1'b1);       // zero against stored zero
      send_text("7c3", 1'b0);

      // random phases, each at its own digit count
      phase_no = 0;
      while (phase_no < 8 || items_sent < 320) begin
         wait_drained();
         write_sig_digits(phase_no < 8 ? cfg_vals[phase_no] : SIG_W'($urandom_range(0, 63)));
         @(posedge clock);
         no_idle = (phase_no == 1);
         if (phase_no == 3) rsp_hold_req = 1'b1;
         if (phase_no == 4 || phase_no == 5) begin
            build_long(phase_no == 5);
            send_number(phase_no == 5);
         end
         repeat (3) begin
            which = have_first ? 1'($urandom_range(0, 1)) : 1'b0;
            build_random(which);
            send_number(which);
         end
         phase_no++;
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dnc_pkg.sv
rtl/dnc_ctrl.sv
rtl/dnc_datapath.sv
rtl/decimal_normalize_compare_unit.sv
dv/dnc_result_checker.sv
dv/tb_decimal_normalize_compare_unit.sv
